>>> rtl/core/ppdb_pkg.sv
// ---------------------------------------------------------------------------
// ppdb_pkg
// Shared constants, types and register codes for the point projection
// depth buffer.
// ---------------------------------------------------------------------------
package ppdb_pkg;

  // Image geometry
  localparam int IMAGE_WIDTH  = 640;
  localparam int IMAGE_HEIGHT = 480;
  localparam int PIXELS       = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W       = $clog2(PIXELS);
  localparam int MAX_DIM      = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int QUO_W        = $clog2(MAX_DIM);
  localparam int STEP_W       = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  // Field widths
  localparam int COORD_W = 21;
  localparam int DIFF_W  = 22;
  localparam int COEF_W  = 18;
  localparam int PROD_W  = 40;
  localparam int VEC_W   = 42;
  localparam int NUM_W   = 60;
  localparam int ZS_W    = 52;
  localparam int ZINT_W  = ZS_W - 32;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int DEPTH_W = 16;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 63;
  localparam int ROT_W   = 54;

  localparam int MM_PER_METRE = 1000;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_ROT_X       = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROT_Y       = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROT_Z       = 3'd2;
  localparam logic [IDX_W-1:0] REG_CAM_POS     = 3'd3;
  localparam logic [IDX_W-1:0] REG_FOCAL       = 3'd4;
  localparam logic [IDX_W-1:0] REG_PRINCIPAL   = 3'd5;
  localparam logic [IDX_W-1:0] REG_DEPTH_LIMIT = 3'd6;

  // Register reset values
  localparam logic [ROT_W-1:0]   ROT_X_RESET       = 54'd65536;
  localparam logic [ROT_W-1:0]   ROT_Y_RESET       = 54'd17179869184;
  localparam logic [ROT_W-1:0]   ROT_Z_RESET       = 54'd4503599627370496;
  localparam logic [31:0]        FOCAL_RESET       = 32'd551035096;
  localparam logic [31:0]        PRINCIPAL_RESET   = 32'd251663360;
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RESET = 16'd10000;

  localparam int QUEUE_DEPTH = 2;

  // Classified work item passed from front to back
  typedef struct packed {
    logic               is_read;
    logic               hit;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               depth_ok;
    logic [DEPTH_W-1:0] depth;
  } cmd_t;

endpackage

>>> rtl/core/ppdb_queue.sv
// ---------------------------------------------------------------------------
// ppdb_queue
// Short command queue between the projection front and the buffer back.
// ---------------------------------------------------------------------------
module ppdb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ppdb_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output ppdb_pkg::cmd_t head
);

  localparam int PTR_W = (ppdb_pkg::QUEUE_DEPTH > 1) ? $clog2(ppdb_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ppdb_pkg::QUEUE_DEPTH + 1);

  ppdb_pkg::cmd_t   slots [ppdb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(ppdb_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Pointer and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        slots[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PTR_W'(ppdb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(ppdb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/ppdb_front.sv
// ---------------------------------------------------------------------------
// ppdb_front
// Accepts items, holds configuration, and projects points with a shared
// multiply-accumulate, a shift-add multiplier and a restoring divider.
// ---------------------------------------------------------------------------
module ppdb_front (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic signed [ppdb_pkg::COORD_W-1:0] point_x,
  input  logic signed [ppdb_pkg::COORD_W-1:0] point_y,
  input  logic signed [ppdb_pkg::COORD_W-1:0] point_z,
  input  logic [ppdb_pkg::COL_W-1:0]       read_col,
  input  logic [ppdb_pkg::ROW_W-1:0]       read_row,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ppdb_pkg::IDX_W-1:0]       cfg_index,
  input  logic [ppdb_pkg::CFG_W-1:0]       cfg_data,
  // back side
  input  logic                             clearing,
  output logic                             push,
  output ppdb_pkg::cmd_t                   push_data,
  input  logic                             full
);

  typedef enum logic [2:0] {
    F_IDLE, F_ROT, F_CHK, F_MUL, F_DSET, F_DIV, F_FIN, F_PUSH
  } fstate_t;

  fstate_t state;

  logic [ppdb_pkg::ROT_W-1:0]   rot_x, rot_y, rot_z;
  logic [ppdb_pkg::CFG_W-1:0]   cam;
  logic [31:0]                  focal, ppt;
  logic [ppdb_pkg::DEPTH_W-1:0] depth_limit;

  logic signed [ppdb_pkg::DIFF_W-1:0] d0, d1, d2;
  logic signed [ppdb_pkg::VEC_W-1:0]  vx, vy, vz;
  logic [1:0]                         rsel, ksel;
  logic signed [ppdb_pkg::NUM_W-1:0]  mvx, mvy, mvz, nu, nv;
  logic [15:0]                        fxs, fys, cxs, cys;
  logic [3:0]                         bitcnt;
  logic [ppdb_pkg::NUM_W-1:0]         remu, remv, dsh;
  logic [ppdb_pkg::QUO_W-1:0]         qu, qv;
  logic                               negu, negv, ovu, ovv;
  logic [ppdb_pkg::STEP_W-1:0]        stepcnt;
  ppdb_pkg::cmd_t                     cmd;

  logic [ppdb_pkg::ROT_W-1:0]         row_sel;
  logic signed [ppdb_pkg::COEF_W-1:0] coef;
  logic signed [ppdb_pkg::DIFF_W-1:0] dsel;
  logic signed [ppdb_pkg::PROD_W-1:0] prod;
  logic signed [ppdb_pkg::ZS_W-1:0]   zs;
  logic [ppdb_pkg::ZINT_W-1:0]        zs_int;
  logic [ppdb_pkg::VEC_W-1:0]         abs_vz;
  logic [ppdb_pkg::NUM_W-1:0]         den, abs_nu, abs_nv;
  logic                               u_ok, v_ok;
  logic                               read_hit;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != F_IDLE) || clearing;
  assign push      = (state == F_PUSH) && !full;
  assign push_data = cmd;

  // read item addresses a pixel inside the image
  assign read_hit = op &&
                    (read_col < ppdb_pkg::COL_W'(ppdb_pkg::IMAGE_WIDTH)) &&
                    (read_row < ppdb_pkg::ROW_W'(ppdb_pkg::IMAGE_HEIGHT));

  // Rotation operand select
  always_comb begin
    case (rsel)
      2'd0:    row_sel = rot_x;
      2'd1:    row_sel = rot_y;
      default: row_sel = rot_z;
    endcase
    case (ksel)
      2'd0: begin
        coef = $signed(row_sel[17:0]);
        dsel = d0;
      end
      2'd1: begin
        coef = $signed(row_sel[35:18]);
        dsel = d1;
      end
      default: begin
        coef = $signed(row_sel[53:36]);
        dsel = d2;
      end
    endcase
  end

  assign prod   = ppdb_pkg::PROD_W'(coef) * ppdb_pkg::PROD_W'(dsel);
  assign zs     = ppdb_pkg::ZS_W'(vz) * ppdb_pkg::ZS_W'(ppdb_pkg::MM_PER_METRE);
  assign zs_int = zs[ppdb_pkg::ZS_W-1:32];
  assign abs_vz = vz[ppdb_pkg::VEC_W-1] ? ppdb_pkg::VEC_W'(-vz) : ppdb_pkg::VEC_W'(vz);
  assign den    = ppdb_pkg::NUM_W'(abs_vz) << 4;
  assign abs_nu = nu[ppdb_pkg::NUM_W-1] ? ppdb_pkg::NUM_W'(-nu) : ppdb_pkg::NUM_W'(nu);
  assign abs_nv = nv[ppdb_pkg::NUM_W-1] ? ppdb_pkg::NUM_W'(-nv) : ppdb_pkg::NUM_W'(nv);

  // Range test on truncated quotients; a negative fraction truncates to 0
  assign u_ok = !ovu && !(negu && (qu != '0)) && (qu <= ppdb_pkg::QUO_W'(ppdb_pkg::IMAGE_WIDTH - 1));
  assign v_ok = !ovv && !(negv && (qv != '0)) && (qv <= ppdb_pkg::QUO_W'(ppdb_pkg::IMAGE_HEIGHT - 1));

  // Sequencer, configuration and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      rot_x       <= ppdb_pkg::ROT_X_RESET;
      rot_y       <= ppdb_pkg::ROT_Y_RESET;
      rot_z       <= ppdb_pkg::ROT_Z_RESET;
      cam         <= '0;
      focal       <= ppdb_pkg::FOCAL_RESET;
      ppt         <= ppdb_pkg::PRINCIPAL_RESET;
      depth_limit <= ppdb_pkg::DEPTH_LIMIT_RESET;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          ppdb_pkg::REG_ROT_X:       rot_x       <= cfg_data[ppdb_pkg::ROT_W-1:0];
          ppdb_pkg::REG_ROT_Y:       rot_y       <= cfg_data[ppdb_pkg::ROT_W-1:0];
          ppdb_pkg::REG_ROT_Z:       rot_z       <= cfg_data[ppdb_pkg::ROT_W-1:0];
          ppdb_pkg::REG_CAM_POS:     cam         <= cfg_data;
          ppdb_pkg::REG_FOCAL:       focal       <= cfg_data[31:0];
          ppdb_pkg::REG_PRINCIPAL:   ppt         <= cfg_data[31:0];
          ppdb_pkg::REG_DEPTH_LIMIT: depth_limit <= cfg_data[ppdb_pkg::DEPTH_W-1:0];
          default: ;
        endcase
      end

      case (state)
        F_IDLE: begin
          if (in_valid && !clearing) begin
            d0 <= ppdb_pkg::DIFF_W'(point_x) - ppdb_pkg::DIFF_W'($signed(cam[20:0]));
            d1 <= ppdb_pkg::DIFF_W'(point_y) - ppdb_pkg::DIFF_W'($signed(cam[41:21]));
            d2 <= ppdb_pkg::DIFF_W'(point_z) - ppdb_pkg::DIFF_W'($signed(cam[62:42]));
            cmd.is_read  <= op;
            cmd.hit      <= read_hit;
            cmd.col      <= read_hit ? read_col : '0;
            cmd.row      <= read_hit ? read_row : '0;
            cmd.depth_ok <= 1'b0;
            cmd.depth    <= '0;
            if (op) begin
              state <= F_PUSH;
            end else begin
              vx    <= '0;
              vy    <= '0;
              vz    <= '0;
              rsel  <= '0;
              ksel  <= '0;
              state <= F_ROT;
            end
          end
        end

        // one coefficient product per cycle
        F_ROT: begin
          case (rsel)
            2'd0:    vx <= vx + ppdb_pkg::VEC_W'(prod);
            2'd1:    vy <= vy + ppdb_pkg::VEC_W'(prod);
            default: vz <= vz + ppdb_pkg::VEC_W'(prod);
          endcase
          if (ksel == 2'd2) begin
            ksel <= '0;
            if (rsel == 2'd2) begin
              state <= F_CHK;
            end else begin
              rsel <= rsel + 1'b1;
            end
          end else begin
            ksel <= ksel + 1'b1;
          end
        end

        // depth test values and multiplier setup
        F_CHK: begin
          if (vz == '0) begin
            state <= F_PUSH;
          end else begin
            cmd.depth_ok <= !vz[ppdb_pkg::VEC_W-1] &&
                            (zs_int < ppdb_pkg::ZINT_W'(depth_limit));
            cmd.depth    <= zs_int[ppdb_pkg::DEPTH_W-1:0];
            mvx    <= ppdb_pkg::NUM_W'(vx);
            mvy    <= ppdb_pkg::NUM_W'(vy);
            mvz    <= ppdb_pkg::NUM_W'(vz);
            nu     <= '0;
            nv     <= '0;
            fxs    <= focal[15:0];
            fys    <= focal[31:16];
            cxs    <= ppt[15:0];
            cys    <= ppt[31:16];
            bitcnt <= '0;
            state  <= F_MUL;
          end
        end

        // shift-add: nu = vx*fx + cx*vz, nv = vy*fy + cy*vz
        F_MUL: begin
          nu <= nu + (fxs[0] ? mvx : '0) + (cxs[0] ? mvz : '0);
          nv <= nv + (fys[0] ? mvy : '0) + (cys[0] ? mvz : '0);
          mvx <= mvx <<< 1;
          mvy <= mvy <<< 1;
          mvz <= mvz <<< 1;
          fxs <= fxs >> 1;
          fys <= fys >> 1;
          cxs <= cxs >> 1;
          cys <= cys >> 1;
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == 4'd15) begin
            state <= F_DSET;
          end
        end

        // divider setup on magnitudes
        F_DSET: begin
          negu    <= nu[ppdb_pkg::NUM_W-1] ^ vz[ppdb_pkg::VEC_W-1];
          negv    <= nv[ppdb_pkg::NUM_W-1] ^ vz[ppdb_pkg::VEC_W-1];
          remu    <= abs_nu;
          remv    <= abs_nv;
          ovu     <= abs_nu >= (den << ppdb_pkg::QUO_W);
          ovv     <= abs_nv >= (den << ppdb_pkg::QUO_W);
          dsh     <= den << (ppdb_pkg::QUO_W - 1);
          qu      <= '0;
          qv      <= '0;
          stepcnt <= ppdb_pkg::STEP_W'(ppdb_pkg::QUO_W - 1);
          state   <= F_DIV;
        end

        // restoring division, one quotient bit per cycle
        F_DIV: begin
          if (remu >= dsh) begin
            remu <= remu - dsh;
            qu   <= {qu[ppdb_pkg::QUO_W-2:0], 1'b1};
          end else begin
            qu   <= {qu[ppdb_pkg::QUO_W-2:0], 1'b0};
          end
          if (remv >= dsh) begin
            remv <= remv - dsh;
            qv   <= {qv[ppdb_pkg::QUO_W-2:0], 1'b1};
          end else begin
            qv   <= {qv[ppdb_pkg::QUO_W-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          stepcnt <= stepcnt - 1'b1;
          if (stepcnt == '0) begin
            state <= F_FIN;
          end
        end

        F_FIN: begin
          if (u_ok && v_ok) begin
            cmd.hit <= 1'b1;
            cmd.col <= ppdb_pkg::COL_W'(qu);
            cmd.row <= ppdb_pkg::ROW_W'(qv);
          end else begin
            cmd.depth_ok <= 1'b0;
            cmd.depth    <= '0;
          end
          state <= F_PUSH;
        end

        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end

        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/ppdb_back.sv
// ---------------------------------------------------------------------------
// ppdb_back
// Depth buffer memory: clearing pass, read-and-clear, depth test and write.
// ---------------------------------------------------------------------------
module ppdb_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         empty,
  input  ppdb_pkg::cmd_t               head,
  output logic                         pop,
  output logic                         clearing,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         in_view,
  output logic                         was_written,
  output logic [ppdb_pkg::COL_W-1:0]   pixel_col,
  output logic [ppdb_pkg::ROW_W-1:0]   pixel_row,
  output logic [ppdb_pkg::DEPTH_W-1:0] depth_mm
);

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_WAIT, B_OUT} bstate_t;

  bstate_t state;

  logic [ppdb_pkg::DEPTH_W-1:0] mem [ppdb_pkg::PIXELS];
  logic [ppdb_pkg::DEPTH_W-1:0] rdata;
  logic [ppdb_pkg::ADDR_W-1:0]  raddr, addr, clr_addr;
  logic [ppdb_pkg::ADDR_W-1:0]  waddr;
  logic [ppdb_pkg::DEPTH_W-1:0] wdata;
  logic                         we;
  logic                         take;
  ppdb_pkg::cmd_t               cur;

  assign clearing  = (state == B_CLEAR);
  assign pop       = (state == B_IDLE) && !empty;
  assign out_valid = (state == B_OUT);
  assign raddr     = ppdb_pkg::ADDR_W'(head.row) * ppdb_pkg::ADDR_W'(ppdb_pkg::IMAGE_WIDTH) +
                     ppdb_pkg::ADDR_W'(head.col);

  // new depth wins when the pixel is empty or farther
  assign take = cur.depth_ok && ((rdata == '0) || (rdata > cur.depth));

  // Memory write port
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = '0;
    if (state == B_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
    end else if (state == B_WAIT) begin
      if (cur.is_read) begin
        we = 1'b1;
      end else if (take) begin
        we    = 1'b1;
        wdata = cur.depth;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ppdb_pkg::ADDR_W'(ppdb_pkg::PIXELS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!empty) begin
            cur         <= head;
            addr        <= raddr;
            in_view     <= head.hit;
            was_written <= 1'b0;
            pixel_col   <= head.col;
            pixel_row   <= head.row;
            depth_mm    <= '0;
            state       <= head.hit ? B_WAIT : B_OUT;
          end
        end
        B_WAIT: begin
          if (cur.is_read) begin
            depth_mm <= rdata;
          end else if (take) begin
            was_written <= 1'b1;
            depth_mm    <= cur.depth;
          end
          state <= B_OUT;
        end
        B_OUT: begin
          if (!out_stall) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_written_in_view: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_written |-> in_view)
    else $error("written result outside view");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_view |-> pixel_col == '0 && pixel_row == '0 && depth_mm == '0)
    else $error("out-of-view result not zero");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    state == B_CLEAR |-> !pop && !out_valid)
    else $error("queue activity during clearing pass");
  a_wait_to_out: assert property (@(posedge clk) disable iff (rst)
    state == B_WAIT |=> state == B_OUT)
    else $error("memory access did not complete");
`endif

endmodule

>>> rtl/core/point_projection_depth_buffer.sv
// ---------------------------------------------------------------------------
// point_projection_depth_buffer
// Pinhole point projection into a 640x480 16-bit depth buffer.
// ---------------------------------------------------------------------------
// After reset the block sweeps the depth buffer to empty, one pixel per cycle,
// and holds in_stall high until that pass ends. A point item passes through
// the projection front in steps: the shared rotation multiply-accumulate,
// the shift-add intrinsics multiplier and the restoring divider, plus setup
// steps; a read item goes straight from idle to the push state. The buffer
// back handles each item around the depth memory (one read and one write
// port), and a two-entry queue between them lets the front start the next
// item while a result waits on out_stall.
module point_projection_depth_buffer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic signed [ppdb_pkg::COORD_W-1:0] point_x,
  input  logic signed [ppdb_pkg::COORD_W-1:0] point_y,
  input  logic signed [ppdb_pkg::COORD_W-1:0] point_z,
  input  logic [ppdb_pkg::COL_W-1:0]       read_col,
  input  logic [ppdb_pkg::ROW_W-1:0]       read_row,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             in_view,
  output logic                             was_written,
  output logic [ppdb_pkg::COL_W-1:0]       pixel_col,
  output logic [ppdb_pkg::ROW_W-1:0]       pixel_row,
  output logic [ppdb_pkg::DEPTH_W-1:0]     depth_mm,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ppdb_pkg::IDX_W-1:0]       cfg_index,
  input  logic [ppdb_pkg::CFG_W-1:0]       cfg_data
);

  logic           clearing, push, full, pop, empty;
  ppdb_pkg::cmd_t push_data, head;

  ppdb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .read_col  (read_col),
    .read_row  (read_row),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  ppdb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  ppdb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .head        (head),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .in_view     (in_view),
    .was_written (was_written),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row),
    .depth_mm    (depth_mm)
  );

endmodule

>>> bench/point_projection_depth_buffer_tb.sv
// ----------------------------------------------------------------------------
// point_projection_depth_buffer_tb
// Self-checking bench for the point projection depth buffer. A scoreboard
// class keeps its own camera registers and its own copy of the depth buffer.
// It predicts the result of every accepted item, and it checks every result
// transfer in order. The run covers several camera setups, including zero
// and full depth limits, full-range rotations and offsets. Both sides idle at
// random, and the last phase has no idling at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_projection_depth_buffer_tb;

  localparam int WATCHDOG_LIMIT = 1500000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int PHASE_ITEMS    = 75;
  localparam int NUM_PHASES     = 6;
  localparam bit OP_POINT       = 1'b0;
  localparam bit OP_READ        = 1'b1;

  typedef struct packed {
    logic                         in_view;
    logic                         was_written;
    logic [ppdb_pkg::COL_W-1:0]   col;
    logic [ppdb_pkg::ROW_W-1:0]   row;
    logic [ppdb_pkg::DEPTH_W-1:0] depth;
  } pixel_result_t;

  // Depth buffer predictor and the queue of expected pixel results
  class depth_scoreboard;
    logic [ppdb_pkg::ROT_W-1:0]   rot [3];
    logic [ppdb_pkg::CFG_W-1:0]   cam_pos;
    logic [31:0]                  focal;
    logic [31:0]                  principal;
    logic [ppdb_pkg::DEPTH_W-1:0] depth_limit;
    logic [ppdb_pkg::DEPTH_W-1:0] depth_mem [ppdb_pkg::PIXELS];
    pixel_result_t                expected_q [$];
    int                           written_col [$];
    int                           written_row [$];
    int                           errors;

    function new();
      rot[0] = ppdb_pkg::ROT_X_RESET;
      rot[1] = ppdb_pkg::ROT_Y_RESET;
      rot[2] = ppdb_pkg::ROT_Z_RESET;
      cam_pos = '0;
      focal = ppdb_pkg::FOCAL_RESET;
      principal = ppdb_pkg::PRINCIPAL_RESET;
      depth_limit = ppdb_pkg::DEPTH_LIMIT_RESET;
      foreach (depth_mem[i]) depth_mem[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [ppdb_pkg::IDX_W-1:0] idx,
                            logic [ppdb_pkg::CFG_W-1:0] data);
      case (idx)
        ppdb_pkg::REG_ROT_X:       rot[0] = data[ppdb_pkg::ROT_W-1:0];
        ppdb_pkg::REG_ROT_Y:       rot[1] = data[ppdb_pkg::ROT_W-1:0];
        ppdb_pkg::REG_ROT_Z:       rot[2] = data[ppdb_pkg::ROT_W-1:0];
        ppdb_pkg::REG_CAM_POS:     cam_pos = data;
        ppdb_pkg::REG_FOCAL:       focal = data[31:0];
        ppdb_pkg::REG_PRINCIPAL:   principal = data[31:0];
        ppdb_pkg::REG_DEPTH_LIMIT: depth_limit = data[ppdb_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    endfunction

    function longint rotate_row(logic [ppdb_pkg::ROT_W-1:0] r, longint d[3]);
      longint acc;
      acc = 0;
      for (int k = 0; k < 3; k++) acc += longint'($signed(r[18*k +: 18])) * d[k];
      return acc;
    endfunction

    // Predict one item and update the buffer copy
    function void note_item(bit op, logic signed [ppdb_pkg::COORD_W-1:0] px, py, pz,
                            logic [ppdb_pkg::COL_W-1:0] rc,
                            logic [ppdb_pkg::ROW_W-1:0] rr);
      pixel_result_t r;
      longint d[3];
      longint vx, vy, vz, fx, fy, cx, cy, u, v, zs;
      int idx;
      logic [ppdb_pkg::DEPTH_W-1:0] old;
      r = '0;
      if (op == OP_READ) begin
        if (rc < ppdb_pkg::IMAGE_WIDTH && rr < ppdb_pkg::IMAGE_HEIGHT) begin
          idx = int'(rr) * ppdb_pkg::IMAGE_WIDTH + int'(rc);
          r.in_view = 1'b1;
          r.col = rc;
          r.row = rr;
          r.depth = depth_mem[idx];
          depth_mem[idx] = '0;
        end
      end else begin
        d[0] = longint'(px) - longint'($signed(cam_pos[20:0]));
        d[1] = longint'(py) - longint'($signed(cam_pos[41:21]));
        d[2] = longint'(pz) - longint'($signed(cam_pos[62:42]));
        vx = rotate_row(rot[0], d);
        vy = rotate_row(rot[1], d);
        vz = rotate_row(rot[2], d);
        if (vz != 0) begin
          fx = longint'(focal[15:0]);
          fy = longint'(focal[31:16]);
          cx = longint'(principal[15:0]);
          cy = longint'(principal[31:16]);
          // signed division truncates toward zero
          u = (vx * fx + cx * vz) / (vz * 16);
          v = (vy * fy + cy * vz) / (vz * 16);
          if (u >= 0 && u < ppdb_pkg::IMAGE_WIDTH && v >= 0 &&
              v < ppdb_pkg::IMAGE_HEIGHT) begin
            r.in_view = 1'b1;
            r.col = u[ppdb_pkg::COL_W-1:0];
            r.row = v[ppdb_pkg::ROW_W-1:0];
            idx = int'(v) * ppdb_pkg::IMAGE_WIDTH + int'(u);
            old = depth_mem[idx];
            zs = vz * ppdb_pkg::MM_PER_METRE;
            if (vz > 0 && zs < (longint'(depth_limit) <<< 32) &&
                (old == 0 || (longint'(old) <<< 32) > zs)) begin
              r.was_written = 1'b1;
              r.depth = zs[47:32];
              depth_mem[idx] = zs[47:32];
              written_col.insert(written_col.size(), int'(u));
              written_row.insert(written_row.size(), int'(v));
            end
          end
        end
      end
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(pixel_result_t got);
      pixel_result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result transfer", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.in_view !== want.in_view) report("in_view", got.in_view, want.in_view);
        if (got.was_written !== want.was_written)
          report("was_written", got.was_written, want.was_written);
        if (got.col !== want.col) report("pixel_col", got.col, want.col);
        if (got.row !== want.row) report("pixel_row", got.row, want.row);
        if (got.depth !== want.depth) report("depth_mm", got.depth, want.depth);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = OP_POINT;
  logic signed [ppdb_pkg::COORD_W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic [ppdb_pkg::COL_W-1:0] read_col = '0;
  logic [ppdb_pkg::ROW_W-1:0] read_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic in_view, was_written;
  logic [ppdb_pkg::COL_W-1:0] pixel_col;
  logic [ppdb_pkg::ROW_W-1:0] pixel_row;
  logic [ppdb_pkg::DEPTH_W-1:0] depth_mm;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ppdb_pkg::IDX_W-1:0] cfg_index = ppdb_pkg::REG_ROT_X;
  logic [ppdb_pkg::CFG_W-1:0] cfg_data = '0;

  depth_scoreboard sb;
  bit quiet;
  int stall_left;
  int idle_cycles;
  logic signed [ppdb_pkg::COORD_W-1:0] last_x, last_y, last_z;

  always #4 clk = ~clk;

  point_projection_depth_buffer i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .read_col(read_col), .read_row(read_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .in_view(in_view), .was_written(was_written),
    .pixel_col(pixel_col), .pixel_row(pixel_row), .depth_mm(depth_mm),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Result side: check each transfer, then draw a stall stretch
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result({in_view, was_written, pixel_col, pixel_row, depth_mm});
      stall_left = quiet ? 0 : $urandom_range(0, 5);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task cfg_write(logic [ppdb_pkg::IDX_W-1:0] idx, logic [ppdb_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task send_item(bit o, logic signed [ppdb_pkg::COORD_W-1:0] px, py, pz,
                 logic [ppdb_pkg::COL_W-1:0] rc, logic [ppdb_pkg::ROW_W-1:0] rr);
    int gap;
    in_valid <= 1'b1;
    op <= o;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    read_col <= rc;
    read_row <= rr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(o, px, py, pz, rc, rr);
    if (o == OP_POINT) begin
      last_x = px;
      last_y = py;
      last_z = pz;
    end
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task point_at(int x, int y, int z);
    send_item(OP_POINT, x[ppdb_pkg::COORD_W-1:0], y[ppdb_pkg::COORD_W-1:0],
              z[ppdb_pkg::COORD_W-1:0], '0, '0);
  endtask

  task read_at(int c, int r);
    send_item(OP_READ, ppdb_pkg::COORD_W'($urandom()), ppdb_pkg::COORD_W'($urandom()),
              ppdb_pkg::COORD_W'($urandom()), c[ppdb_pkg::COL_W-1:0],
              r[ppdb_pkg::ROW_W-1:0]);
  endtask

  // Wait for all results, then let the pipeline settle before a register write
  task drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random items: mostly points inside the view volume, plus reads and noise
  task random_items(int n);
    int sel, z, k;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        z = $urandom_range(2000, 1000000);
        point_at($urandom_range(0, z) - z / 2, $urandom_range(0, z) - z / 2, z);
      end else if (sel < 65) begin
        point_at(last_x * 7 / 8, last_y * 7 / 8, last_z * 7 / 8);
      end else if (sel < 88) begin
        if (sb.written_col.size() != 0 && $urandom_range(0, 2) != 0) begin
          k = $urandom_range(0, sb.written_col.size() - 1);
          read_at(sb.written_col[k], sb.written_row[k]);
          sb.written_col.delete(k);
          sb.written_row.delete(k);
        end else begin
          read_at($urandom_range(0, 1023), $urandom_range(0, 511));
        end
      end else begin
        send_item(1'($urandom_range(0, 1)), ppdb_pkg::COORD_W'($urandom()),
                  ppdb_pkg::COORD_W'($urandom()), ppdb_pkg::COORD_W'($urandom()),
                  ppdb_pkg::COL_W'($urandom()), ppdb_pkg::ROW_W'($urandom()));
      end
    end
  endtask

  function automatic logic [ppdb_pkg::ROT_W-1:0] rot_pack(int a, int b, int c);
    return {c[17:0], b[17:0], a[17:0]};
  endfunction

  initial begin
    sb = new();
    quiet = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    last_x = '0;
    last_y = '0;
    last_z = 21'sd65536;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed items with the reset camera
    point_at(0, 0, 65536);
    point_at(0, 0, 131072);          // farther, same pixel: kept out
    point_at(0, 0, 32768);           // nearer: replaces
    point_at(5, 5, 0);               // zero camera depth
    point_at(0, 0, -65536);          // behind the camera
    point_at(-39950, 0, 65536);      // projection just below zero column
    point_at(0, -29000, 65536);
    point_at(-1048576, -1048576, 1048575);
    point_at(1048575, 1048575, 1048575);
    point_at(0, 0, 1048575);         // beyond the depth limit
    point_at(-1048576, 1048575, -1048576);
    point_at(100, 100, 1);
    read_at(320, 240);
    read_at(320, 240);               // already cleared
    read_at(640, 0);
    read_at(0, 480);
    read_at(1023, 511);
    read_at(639, 479);
    read_at(0, 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: begin
            cfg_write(ppdb_pkg::REG_ROT_X, ppdb_pkg::CFG_W'(ppdb_pkg::ROT_X_RESET));
            cfg_write(ppdb_pkg::REG_ROT_Y, ppdb_pkg::CFG_W'(ppdb_pkg::ROT_Y_RESET));
            cfg_write(ppdb_pkg::REG_ROT_Z, ppdb_pkg::CFG_W'(ppdb_pkg::ROT_Z_RESET));
            cfg_write(ppdb_pkg::REG_CAM_POS, {21'($urandom_range(0, 8000) - 4000),
                                              21'($urandom_range(0, 8000) - 4000),
                                              21'($urandom_range(0, 8000) - 4000)});
            cfg_write(ppdb_pkg::REG_FOCAL,
                      ppdb_pkg::CFG_W'({16'($urandom_range(2000, 16000)),
                                        16'($urandom_range(2000, 16000))}));
            cfg_write(ppdb_pkg::REG_PRINCIPAL,
                      ppdb_pkg::CFG_W'({16'($urandom_range(0, 7680)),
                                        16'($urandom_range(0, 10240))}));
            cfg_write(ppdb_pkg::REG_DEPTH_LIMIT, ppdb_pkg::CFG_W'(16'hFFFF));
          end
          2: cfg_write(ppdb_pkg::REG_DEPTH_LIMIT, ppdb_pkg::CFG_W'(16'd0));
          3: begin
            cfg_write(ppdb_pkg::REG_DEPTH_LIMIT, ppdb_pkg::CFG_W'(16'd1));
            cfg_write(ppdb_pkg::REG_CAM_POS, '0);
          end
          4: begin
            cfg_write(ppdb_pkg::REG_ROT_X, ppdb_pkg::CFG_W'({$urandom(), $urandom()}));
            cfg_write(ppdb_pkg::REG_ROT_Y,
                      ppdb_pkg::CFG_W'(rot_pack(131071, -131072, 0)));
            cfg_write(ppdb_pkg::REG_ROT_Z, ppdb_pkg::CFG_W'({$urandom(), $urandom()}));
            cfg_write(ppdb_pkg::REG_CAM_POS, ppdb_pkg::CFG_W'({$urandom(), $urandom()}));
            cfg_write(ppdb_pkg::REG_DEPTH_LIMIT,
                      ppdb_pkg::CFG_W'($urandom_range(1, 65535)));
          end
          default: begin
            quiet = 1'b1;
            cfg_write(ppdb_pkg::REG_ROT_X, ppdb_pkg::CFG_W'(rot_pack(0, -65536, 0)));
            cfg_write(ppdb_pkg::REG_ROT_Y, ppdb_pkg::CFG_W'(rot_pack(65536, 0, 0)));
            cfg_write(ppdb_pkg::REG_ROT_Z, ppdb_pkg::CFG_W'(rot_pack(0, 0, 65536)));
            cfg_write(ppdb_pkg::REG_CAM_POS, '0);
            cfg_write(ppdb_pkg::REG_FOCAL, ppdb_pkg::CFG_W'(32'hFFFF_FFFF));
            cfg_write(ppdb_pkg::REG_PRINCIPAL, '0);
            cfg_write(ppdb_pkg::REG_DEPTH_LIMIT, ppdb_pkg::CFG_W'(16'd10000));
          end
        endcase
      end
      random_items(PHASE_ITEMS);
    end

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
